// ===== rtl/imuvgr_pkg.sv =====
// Shared constants, types and state codes of the IMU grid resampler.
package imuvgr_pkg;

    localparam int TIME_W   = 48;
    localparam int PER_W    = 20;
    localparam int COMP_W   = 32;
    localparam int MAX_FILL = 16;
    localparam int NAXIS    = 3;

    localparam int DIV_LW = (COMP_W > TIME_W) ? COMP_W : TIME_W;
    localparam int ITER_W = $clog2(DIV_LW + 1);
    localparam int K_W    = $clog2(MAX_FILL + 1);
    localparam int PROD_W = COMP_W + PER_W;
    localparam int IDX_W  = $clog2(NAXIS);

    localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(10000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TDIV,
        S_MUL,
        S_SSTART,
        S_SDIV,
        S_EMIT
    } t_state;

    typedef enum logic {
        TM_ALIGN,
        TM_GAP
    } t_tmode;

    typedef enum logic {
        SM_PART,
        SM_COMP
    } t_smode;

    typedef struct packed {
        logic              start;
        logic [PER_W-1:0]  rem_init;
        logic [DIV_LW-1:0] num;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_LW-1:0] quot;
        logic [PER_W-1:0]  rem;
    } t_div_rsp;

endpackage

// ===== rtl/imuvgr_in_if.sv =====
// Input sample channel: valid/ready handshake with timestamp and three components.
interface imuvgr_in_if;
    import imuvgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        sample_time_us;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;

    modport source (output valid, sample_time_us, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, sample_time_us, comp_x, comp_y, comp_z, output ready);
endinterface

// ===== rtl/imuvgr_out_if.sv =====
// Result channel: valid/ready handshake with grid time, components and flags.
interface imuvgr_out_if;
    import imuvgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        grid_time_us;
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic                     overrun;
    logic                     last_of_run;

    modport source (output valid, grid_time_us, out_x, out_y, out_z, overrun, last_of_run,
                    input ready);
    modport sink   (input valid, grid_time_us, out_x, out_y, out_z, overrun, last_of_run,
                    output ready);
endinterface

// ===== rtl/imuvgr_div.sv =====
// Shared restoring divider, one quotient bit per cycle, divisor below 2^PER_W.
module imuvgr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imuvgr_pkg::t_div_req                i_req,
    input  logic [imuvgr_pkg::PER_W-1:0]        i_divisor,
    output imuvgr_pkg::t_div_rsp                o_rsp
);
    import imuvgr_pkg::*;

    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [PER_W-1:0]  r_rem, n_rem;
    logic [DIV_LW-1:0] r_low, n_low;

    logic [PER_W:0]    rem2;
    logic [PER_W:0]    dvs;
    logic              ge;

    assign rem2 = {r_rem, r_low[DIV_LW-1]};
    assign dvs  = {1'b0, i_divisor};
    assign ge   = rem2 >= dvs;

    always_comb begin
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_done = 1'b0;
        if (i_req.start) begin
            n_cnt = i_req.iters;
            n_rem = i_req.rem_init;
            n_low = i_req.num;
        end else if (r_cnt != '0) begin
            n_cnt  = ITER_W'(r_cnt - 1'b1);
            n_rem  = ge ? PER_W'(rem2 - dvs) : rem2[PER_W-1:0];
            n_low  = {r_low[DIV_LW-2:0], ge};
            n_done = (r_cnt == ITER_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/imu_vector_grid_resampler_core.sv =====
// Top level: sequencer and datapath of the time-weighted grid resampler.
//
// Samples enter on i_in (valid/ready, one transaction per sample); grid results
// leave on o_out through an output register. i_cfg_we/i_cfg_wdata write the
// grid period in microseconds; write it only while the block is idle.
// One sample is worked at a time and i_in.ready is high only when idle.
// All divisions run on one shared divider at one bit per cycle:
//   grid alignment or gap division (48 quotient bits),
//   weighting of one component (multiply, 32-bit divide),
//   each weighting pass covering three components.
// A first sample takes an alignment and a weighting pass; one inside the open
// interval a weighting pass; one that completes intervals a gap division, a
// completion pass if partly filled, its results and a weighting pass, and a
// long gap adds another alignment pass. Results of one sample appear at most
// one per cycle, the last with last_of_run set. A stalled receiver holds the
// output register and the sequencer waits in its emit step; nothing is dropped.
// Reset clears the grid state and sets the period to 10000.
module imu_vector_grid_resampler_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    imuvgr_in_if.sink                      i_in,
    imuvgr_out_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic [imuvgr_pkg::PER_W-1:0]   i_cfg_wdata
);
    import imuvgr_pkg::*;

    t_state            r_state, n_state;
    t_tmode            r_tmode, n_tmode;
    t_smode            r_smode, n_smode;
    logic [PER_W-1:0]  r_period, n_period;
    logic              r_started, n_started;
    logic [TIME_W-1:0] r_end, n_end;
    logic [PER_W-1:0]  r_filled, n_filled;
    logic [COMP_W-1:0] r_partial [NAXIS];
    logic [COMP_W-1:0] n_partial [NAXIS];
    logic              r_ov, n_ov;
    logic [K_W-1:0]    r_k, n_k;

    logic [TIME_W-1:0] r_t, n_t;
    logic [COMP_W-1:0] r_c [NAXIS];
    logic [COMP_W-1:0] n_c [NAXIS];
    logic [COMP_W-1:0] r_first [NAXIS];
    logic [COMP_W-1:0] n_first [NAXIS];
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [PER_W-1:0]  r_w, n_w;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic              r_neg, n_neg;
    logic              r_over, n_over;
    logic [K_W-1:0]    r_n, n_n;
    logic [PER_W-1:0]  r_gaprem, n_gaprem;
    logic [TIME_W-1:0] r_o_time, n_o_time;
    logic [COMP_W-1:0] r_o_comp [NAXIS];
    logic [COMP_W-1:0] n_o_comp [NAXIS];
    logic              r_o_over, n_o_over;
    logic              r_o_last, n_o_last;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [PER_W-1:0]  p_eff;
    logic [TIME_W-1:0] back;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] quot_t;
    logic [COMP_W-1:0] c_sel;
    logic [COMP_W-1:0] abs_c;
    logic [COMP_W-1:0] q_sc;
    logic [COMP_W-1:0] res_sc;
    logic [COMP_W:0]   sum;
    logic [COMP_W-1:0] sat_v;
    logic [PER_W-1:0]  comp_w;
    logic              last_k;
    logic              out_free;

    imuvgr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (p_eff),
        .o_rsp     (div_rsp)
    );

    assign p_eff   = (r_period == '0) ? PER_W'(1) : r_period;
    assign back    = r_end - r_t;
    assign gap     = r_t - r_end;
    assign quot_t  = div_rsp.quot[TIME_W-1:0];
    assign c_sel   = r_c[r_idx];
    assign abs_c   = c_sel[COMP_W-1] ? COMP_W'(~c_sel + 1'b1) : c_sel;
    assign q_sc    = div_rsp.quot[COMP_W-1:0];
    assign res_sc  = r_neg ? COMP_W'(~q_sc + 1'b1) : q_sc;
    assign sum     = {r_partial[r_idx][COMP_W-1], r_partial[r_idx]} + {res_sc[COMP_W-1], res_sc};
    assign comp_w  = (r_filled >= p_eff) ? '0 : PER_W'(p_eff - r_filled);
    assign last_k  = (K_W'(r_k + 1'b1) == r_n);
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        unique case (sum[COMP_W:COMP_W-1])
            2'b01:   sat_v = {1'b0, {(COMP_W-1){1'b1}}};
            2'b10:   sat_v = {1'b1, {(COMP_W-1){1'b0}}};
            default: sat_v = sum[COMP_W-1:0];
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_tmode   = r_tmode;
        n_smode   = r_smode;
        n_period  = r_period;
        n_started = r_started;
        n_end     = r_end;
        n_filled  = r_filled;
        n_partial = r_partial;
        n_ov      = r_ov;
        n_k       = r_k;
        n_t       = r_t;
        n_c       = r_c;
        n_first   = r_first;
        n_idx     = r_idx;
        n_w       = r_w;
        n_prod    = r_prod;
        n_neg     = r_neg;
        n_over    = r_over;
        n_n       = r_n;
        n_gaprem  = r_gaprem;
        n_o_time  = r_o_time;
        n_o_comp  = r_o_comp;
        n_o_over  = r_o_over;
        n_o_last  = r_o_last;
        div_req   = '0;

        if (i_cfg_we) n_period = i_cfg_wdata;
        if (r_ov && o_out.ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_t     = i_in.sample_time_us;
                    n_c[0]  = i_in.comp_x;
                    n_c[1]  = i_in.comp_y;
                    n_c[2]  = i_in.comp_z;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_started) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_LW'(r_t) << (DIV_LW - TIME_W);
                    div_req.iters = ITER_W'(TIME_W);
                    n_tmode       = TM_ALIGN;
                    n_state       = S_TDIV;
                end else if (r_t < r_end) begin
                    if (back > TIME_W'(p_eff)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_w     = PER_W'(p_eff - back[PER_W-1:0]);
                        n_smode = SM_PART;
                        n_idx   = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_LW'(gap) << (DIV_LW - TIME_W);
                    div_req.iters = ITER_W'(TIME_W);
                    n_tmode       = TM_GAP;
                    n_state       = S_TDIV;
                end
            end
            S_TDIV: begin
                if (div_rsp.done) begin
                    if (r_tmode == TM_ALIGN) begin
                        n_end     = r_t - TIME_W'(div_rsp.rem) + TIME_W'(p_eff);
                        n_started = 1'b1;
                        n_w       = div_rsp.rem;
                        n_smode   = SM_PART;
                        n_idx     = '0;
                        n_state   = S_MUL;
                    end else begin
                        n_over   = quot_t >= TIME_W'(MAX_FILL);
                        n_n      = (quot_t >= TIME_W'(MAX_FILL)) ? K_W'(MAX_FILL)
                                                                : K_W'(quot_t[K_W-1:0] + 1'b1);
                        n_gaprem = div_rsp.rem;
                        n_k      = '0;
                        if (r_filled != '0) begin
                            n_w     = comp_w;
                            n_smode = SM_COMP;
                            n_idx   = '0;
                            n_state = S_MUL;
                        end else begin
                            n_first = r_c;
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_MUL: begin
                n_prod  = abs_c * r_w;
                n_neg   = c_sel[COMP_W-1];
                n_state = S_SSTART;
            end
            S_SSTART: begin
                div_req.start    = 1'b1;
                div_req.rem_init = r_prod[PROD_W-1:COMP_W];
                div_req.num      = DIV_LW'(r_prod[COMP_W-1:0]) << (DIV_LW - COMP_W);
                div_req.iters    = ITER_W'(COMP_W);
                n_state          = S_SDIV;
            end
            S_SDIV: begin
                if (div_rsp.done) begin
                    if (r_smode == SM_PART) n_partial[r_idx] = res_sc;
                    else                    n_first[r_idx]   = sat_v;
                    if (r_idx == IDX_W'(NAXIS - 1)) begin
                        if (r_smode == SM_PART) begin
                            n_filled = r_w;
                            n_state  = S_IDLE;
                        end else begin
                            n_k     = '0;
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_idx   = IDX_W'(r_idx + 1'b1);
                        n_state = S_MUL;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_time = r_end;
                    n_o_comp = (r_k == '0) ? r_first : r_c;
                    n_o_over = r_over && last_k;
                    n_o_last = last_k;
                    n_end    = r_end + TIME_W'(p_eff);
                    n_filled = '0;
                    n_k      = K_W'(r_k + 1'b1);
                    if (last_k) begin
                        if (r_over) begin
                            div_req.start = 1'b1;
                            div_req.num   = DIV_LW'(r_t) << (DIV_LW - TIME_W);
                            div_req.iters = ITER_W'(TIME_W);
                            n_tmode       = TM_ALIGN;
                            n_state       = S_TDIV;
                        end else begin
                            n_w     = r_gaprem;
                            n_smode = SM_PART;
                            n_idx   = '0;
                            n_state = S_MUL;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tmode   <= TM_ALIGN;
            r_smode   <= SM_PART;
            r_period  <= PERIOD_RESET;
            r_started <= 1'b0;
            r_end     <= '0;
            r_filled  <= '0;
            r_partial <= '{default: '0};
            r_ov      <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_tmode   <= n_tmode;
            r_smode   <= n_smode;
            r_period  <= n_period;
            r_started <= n_started;
            r_end     <= n_end;
            r_filled  <= n_filled;
            r_partial <= n_partial;
            r_ov      <= n_ov;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_c      <= n_c;
        r_first  <= n_first;
        r_idx    <= n_idx;
        r_w      <= n_w;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_over   <= n_over;
        r_n      <= n_n;
        r_gaprem <= n_gaprem;
        r_o_time <= n_o_time;
        r_o_comp <= n_o_comp;
        r_o_over <= n_o_over;
        r_o_last <= n_o_last;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.grid_time_us = r_o_time;
    assign o_out.out_x        = r_o_comp[0];
    assign o_out.out_y        = r_o_comp[1];
    assign o_out.out_z        = r_o_comp[2];
    assign o_out.overrun      = r_o_over;
    assign o_out.last_of_run  = r_o_last;

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < r_n))
        else $error("emit counter past result count");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_CHECK))
        else $error("accepted transaction not taken up");

    a_overrun_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.overrun || o_out.last_of_run))
        else $error("overrun on a result that is not last");

endmodule
